// ----- rtl/core/safl_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted anchor floor lookup package
// Shared anchor record type, request and status codes, and the ordering check
// used on neighboring anchors.
// ----------------------------------------------------------------------------
package safl_pkg;

   typedef struct packed {
      logic [63:0] offset;
      logic [63:0] index;
   } anchor_type;

   typedef logic [1:0] req_code_type;
   typedef logic [1:0] status_code_type;

   localparam req_code_type REQ_CLEAR  = 2'd0;
   localparam req_code_type REQ_APPEND = 2'd1;
   localparam req_code_type REQ_LOOKUP = 2'd2;

   localparam status_code_type STATUS_OK        = 2'd0;
   localparam status_code_type STATUS_NOT_FOUND = 2'd1;
   localparam status_code_type STATUS_MALFORMED = 2'd2;

   // True when the later anchor is strictly above the earlier one in both fields.
   function automatic logic strictly_after(input anchor_type later, input anchor_type earlier);
      strictly_after = (later.index > earlier.index) && (later.offset > earlier.offset);
   endfunction

endpackage

// ----- rtl/core/safl_anchor_ram.sv -----
// ----------------------------------------------------------------------------
// Anchor table memory
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module safl_anchor_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  safl_pkg::anchor_type wr_data,
   input  logic [AW-1:0]        rd_addr,
   output safl_pkg::anchor_type rd_data
);

   safl_pkg::anchor_type mem [DEPTH];
   safl_pkg::anchor_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sorted_anchor_floor_lookup.sv -----
// ----------------------------------------------------------------------------
// Sorted anchor floor lookup
// Anchor table with clear, append and an upper-bound halving search that
// returns the anchor at or below a packet index after a neighbor order check.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req_     in         tuser: request kind; tdata: key_index, anchor_offset
//  rsp_     out        tuser: status; tdata: found_index, found_offset
//
//  Clear and append transfers are handled in the idle state.
//  A lookup makes P halving probes (at most ceil(log2(anchor_count + 1))), each a
//  PROBE and a CMP state on the single memory read port, then reads the found
//  anchor and its neighbors in CUR, PREV and NEXT before EMIT.
//  req_tready is low for the whole lookup; a result waits in an output
//  register and the next request is taken while it is held.
//  Reset is synchronous and empties the table; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_anchor_floor_lookup #(
   parameter int MAX_ANCHORS = 1024
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // [1:0] req_type
   input  logic [127:0] req_tdata,   // [63:0] key_index, [127:64] anchor_offset

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // [1:0] status
   output logic [127:0] rsp_tdata    // [63:0] found_index, [127:64] found_offset
);

   localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
   localparam int CW = $clog2(MAX_ANCHORS + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ANCHORS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PROBE = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_CUR   = 3'd3;
   localparam logic [2:0] ST_PREV  = 3'd4;
   localparam logic [2:0] ST_NEXT  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              first_ff, first_in;
   logic [CW-1:0]              len_ff, len_in;
   logic [CW-1:0]              probe_ff, probe_in;
   logic [CW-1:0]              half_ff, half_in;
   logic [CW-1:0]              found_ff, found_in;
   logic [63:0]                key_ff, key_in;
   safl_pkg::anchor_type       cur_ff, cur_in;
   safl_pkg::status_code_type  res_status_ff, res_status_in;
   safl_pkg::anchor_type       res_anchor_ff, res_anchor_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   safl_pkg::status_code_type  rsp_status_ff, rsp_status_in;
   safl_pkg::anchor_type       rsp_anchor_ff, rsp_anchor_in;

   logic                       wr_en;
   logic [AW-1:0]              rd_addr;
   safl_pkg::anchor_type       wr_data;
   safl_pkg::anchor_type       rd_data;
   logic                       req_fire;
   logic                       has_next;
   logic [CW-1:0]              probe_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_data    = {req_tdata[127:64], req_tdata[63:0]};
   assign wr_en = req_fire && (req_tuser == safl_pkg::REQ_APPEND) && (count_ff < MAX_COUNT);
   assign has_next   = ((found_ff + CW'(1)) < count_ff);
   assign probe_next = first_ff + (len_ff >> 1);

   safl_anchor_ram #(
      .DEPTH (MAX_ANCHORS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      first_in      = first_ff;
      len_in        = len_ff;
      probe_in      = probe_ff;
      half_in       = half_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_anchor_in = res_anchor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_anchor_in = rsp_anchor_ff;
      rd_addr       = probe_next[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  safl_pkg::REQ_CLEAR: begin
                     count_in = '0;
                  end
                  safl_pkg::REQ_APPEND: begin
                     if (count_ff < MAX_COUNT) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  safl_pkg::REQ_LOOKUP: begin
                     key_in   = req_tdata[63:0];
                     first_in = '0;
                     len_in   = count_ff;
                     state_in = ST_PROBE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (len_ff != '0) begin
               probe_in = probe_next;
               half_in  = len_ff >> 1;
               state_in = ST_CMP;
            end else if (first_ff == '0) begin
               res_status_in = safl_pkg::STATUS_NOT_FOUND;
               res_anchor_in = '0;
               state_in      = ST_EMIT;
            end else begin
               found_in = first_ff - CW'(1);
               rd_addr  = found_in[AW-1:0];
               state_in = ST_CUR;
            end
         end
         ST_CMP: begin
            if (key_ff >= rd_data.index) begin
               first_in = probe_ff + CW'(1);
               len_in   = len_ff - half_ff - CW'(1);
            end else begin
               len_in = half_ff;
            end
            state_in = ST_PROBE;
         end
         ST_CUR: begin
            cur_in = rd_data;
            if (found_ff != '0) begin
               rd_addr  = found_ff[AW-1:0] - AW'(1);
               state_in = ST_PREV;
            end else if (has_next) begin
               rd_addr  = found_ff[AW-1:0] + AW'(1);
               state_in = ST_NEXT;
            end else begin
               res_status_in = safl_pkg::STATUS_OK;
               res_anchor_in = rd_data;
               state_in      = ST_EMIT;
            end
         end
         ST_PREV: begin
            if (!safl_pkg::strictly_after(cur_ff, rd_data)) begin
               res_status_in = safl_pkg::STATUS_MALFORMED;
               res_anchor_in = '0;
               state_in      = ST_EMIT;
            end else if (has_next) begin
               rd_addr  = found_ff[AW-1:0] + AW'(1);
               state_in = ST_NEXT;
            end else begin
               res_status_in = safl_pkg::STATUS_OK;
               res_anchor_in = cur_ff;
               state_in      = ST_EMIT;
            end
         end
         ST_NEXT: begin
            if (safl_pkg::strictly_after(rd_data, cur_ff)) begin
               res_status_in = safl_pkg::STATUS_OK;
               res_anchor_in = cur_ff;
            end else begin
               res_status_in = safl_pkg::STATUS_MALFORMED;
               res_anchor_in = '0;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_anchor_in = res_anchor_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      len_ff        <= len_in;
      probe_ff      <= probe_in;
      half_ff       <= half_in;
      found_ff      <= found_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_anchor_ff <= res_anchor_in;
      rsp_status_ff <= rsp_status_in;
      rsp_anchor_ff <= rsp_anchor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_anchor_ff.offset, rsp_anchor_ff.index};

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("Anchor count exceeds the table capacity.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (probe_ff < count_ff))
      else $error("Search probe lies outside the filled part of the table.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != safl_pkg::STATUS_OK) |-> (rsp_tdata == '0))
      else $error("A failed lookup carries nonzero anchor data.");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == safl_pkg::REQ_LOOKUP) |=> !req_tready)
      else $error("Request side stays ready after a lookup transfer.");

endmodule

// ----- test/sorted_anchor_floor_lookup_test.sv -----
// ----------------------------------------------------------------------------
// Sorted anchor floor lookup testbench
// Drives clear, append, lookup and unused request transfers into the block,
// predicts every lookup result from a private copy of the anchor table and
// compares each result transfer field by field. It covers a directed set of
// edge cases, a full table with dropped appends, and random anchor runs,
// under varying source idling, sink stalls and a long sink hold-off.
// ----------------------------------------------------------------------------
module sorted_anchor_floor_lookup_test;

   localparam int TABLE_DEPTH = 1024;
   localparam int TOTAL_TRANSFERS = 1350;
   localparam safl_pkg::req_code_type REQ_UNUSED = 2'd3;

   typedef struct {
      safl_pkg::status_code_type status;
      logic [63:0]               index;
      logic [63:0]               offset;
   } lookup_result_type;

   class anchor_lookup_scoreboard #(int DEPTH = 1024);
      logic [63:0] index_tbl [DEPTH];
      logic [63:0] offset_tbl [DEPTH];
      int unsigned anchor_total;
      lookup_result_type awaited_q [$];
      int errors;

      function new();
         anchor_total = 0;
         errors = 0;
      endfunction

      function int unsigned count_now();
         return anchor_total;
      endfunction

      function int pending();
         return awaited_q.size();
      endfunction

      function bit ascends(int unsigned later, int unsigned earlier);
         return index_tbl[later] > index_tbl[earlier] &&
                offset_tbl[later] > offset_tbl[earlier];
      endfunction

      function lookup_result_type predict_lookup(logic [63:0] key);
         int unsigned lo;
         int unsigned span;
         int unsigned half;
         int unsigned probe;
         int unsigned pos;
         lookup_result_type res;
         lo = 0;
         span = anchor_total;
         while (span > 0) begin
            half = span / 2;
            probe = lo + half;
            if (key >= index_tbl[probe]) begin
               lo = probe + 1;
               span = span - (half + 1);
            end else begin
               span = half;
            end
         end
         res.status = safl_pkg::STATUS_OK;
         res.index = '0;
         res.offset = '0;
         if (lo == 0) begin
            res.status = safl_pkg::STATUS_NOT_FOUND;
         end else begin
            pos = lo - 1;
            if (pos > 0 && !ascends(pos, pos - 1)) begin
               res.status = safl_pkg::STATUS_MALFORMED;
            end else if (pos + 1 < anchor_total && !ascends(pos + 1, pos)) begin
               res.status = safl_pkg::STATUS_MALFORMED;
            end else begin
               res.index = index_tbl[pos];
               res.offset = offset_tbl[pos];
            end
         end
         return res;
      endfunction

      function void note_request(safl_pkg::req_code_type kind, logic [63:0] key,
                                 logic [63:0] off);
         case (kind)
            safl_pkg::REQ_CLEAR: begin
               anchor_total = 0;
            end
            safl_pkg::REQ_APPEND: begin
               if (anchor_total < DEPTH) begin
                  index_tbl[anchor_total] = key;
                  offset_tbl[anchor_total] = off;
                  anchor_total++;
               end
            end
            safl_pkg::REQ_LOOKUP: begin
               awaited_q.push_back(predict_lookup(key));
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(safl_pkg::status_code_type st, logic [63:0] idx,
                                 logic [63:0] off);
         lookup_result_type exp;
         if (awaited_q.size() == 0) begin
            $error("result transfer with none awaited: status %0d", st);
            errors++;
            return;
         end
         exp = awaited_q.pop_front();
         if (st !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, st);
            errors++;
         end
         if (idx !== exp.index) begin
            $error("found_index: expected %h, actual %h", exp.index, idx);
            errors++;
         end
         if (off !== exp.offset) begin
            $error("found_offset: expected %h, actual %h", exp.offset, off);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;     // [1:0] req_type
   logic [127:0] req_tdata = '0;     // [63:0] key_index, [127:64] anchor_offset
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;          // [1:0] status
   logic [127:0] rsp_tdata;          // [63:0] found_index, [127:64] found_offset

   anchor_lookup_scoreboard #(TABLE_DEPTH) sb;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int rsp_hold_left = 0;
   int counted_transfers = 0;

   sorted_anchor_floor_lookup #(
      .MAX_ANCHORS(TABLE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(safl_pkg::req_code_type kind, logic [63:0] key,
                            logic [63:0] off);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {off, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, key, off);
      counted_transfers++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic set_idle_mode(int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 73;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 73;
         end
         default: begin
            send_idle_pct = 16;
            recv_stall_pct = 16;
         end
      endcase
   endtask

   task automatic run_directed();
      send_item(safl_pkg::REQ_LOOKUP, 64'd0, rand64());
      send_item(safl_pkg::REQ_LOOKUP, '1, '1);
      send_item(REQ_UNUSED, '1, '1);
      send_item(safl_pkg::REQ_APPEND, 64'd5, 64'd100);
      send_item(safl_pkg::REQ_APPEND, 64'd10, 64'd200);
      send_item(safl_pkg::REQ_APPEND, 64'hFFFF_FFFF_FFFF_FFFE, '1);
      send_item(safl_pkg::REQ_LOOKUP, 64'd4, '1);
      send_item(safl_pkg::REQ_LOOKUP, 64'd5, 64'd0);
      send_item(safl_pkg::REQ_LOOKUP, 64'd7, rand64());
      send_item(safl_pkg::REQ_LOOKUP, 64'd10, rand64());
      send_item(safl_pkg::REQ_LOOKUP, '1, rand64());
      send_item(safl_pkg::REQ_CLEAR, '1, '1);
      send_item(safl_pkg::REQ_LOOKUP, 64'd5, 64'd0);
      send_item(REQ_UNUSED, 64'd0, 64'd0);
      send_item(safl_pkg::REQ_LOOKUP, 64'd0, 64'd0);
      send_item(safl_pkg::REQ_APPEND, 64'd0, 64'd0);
      send_item(safl_pkg::REQ_LOOKUP, 64'd0, '1);
      send_item(safl_pkg::REQ_APPEND, 64'd0, 64'd5);
      send_item(safl_pkg::REQ_LOOKUP, 64'd0, 64'd0);
      send_item(safl_pkg::REQ_CLEAR, 64'd0, 64'd0);
      send_item(safl_pkg::REQ_APPEND, 64'd10, 64'd50);
      send_item(safl_pkg::REQ_APPEND, 64'd20, 64'd40);
      send_item(safl_pkg::REQ_APPEND, 64'd30, 64'd60);
      send_item(safl_pkg::REQ_LOOKUP, 64'd10, 64'd0);
      send_item(safl_pkg::REQ_LOOKUP, 64'd30, 64'd0);
      drain_results();
   endtask

   task automatic fill_table();
      int i;
      send_item(safl_pkg::REQ_CLEAR, rand64(), rand64());
      for (i = 0; i < TABLE_DEPTH + 4; i++) begin
         if (i < TABLE_DEPTH) begin
            send_item(safl_pkg::REQ_APPEND, 64'(i) * 64'd7 + 64'd3,
                      64'(i) * 64'd11 + 64'h8000_0000_0000_0000);
         end else begin
            send_item(safl_pkg::REQ_APPEND, rand64(), rand64());
         end
      end
      send_item(safl_pkg::REQ_LOOKUP, 64'd0, rand64());
      send_item(safl_pkg::REQ_LOOKUP, 64'd3, rand64());
      send_item(safl_pkg::REQ_LOOKUP, 64'(TABLE_DEPTH - 1) * 64'd7 + 64'd3, rand64());
      send_item(safl_pkg::REQ_LOOKUP, '1, rand64());
      for (i = 0; i < 16; i++) begin
         send_item(safl_pkg::REQ_LOOKUP, 64'($urandom_range(TABLE_DEPTH * 7 + 10)),
                   rand64());
      end
      drain_results();
   endtask

   task automatic run_sequence();
      logic [63:0] idx;
      logic [63:0] off;
      logic [63:0] key;
      logic [63:0] keys [$];
      int n;
      int m;
      int i;
      int bad_at;
      int style;
      int stride;
      if (sb.count_now() > 200 || $urandom_range(7) != 0) begin
         send_item(safl_pkg::REQ_CLEAR, rand64(), rand64());
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 16) : $urandom_range(10, 0);
      bad_at = ($urandom_range(3) == 0) ? $urandom_range(n) : -1;
      style = $urandom_range(2);
      stride = (style == 1) ? 3 : 1000;
      case (style)
         0: begin
            idx = rand64();
            off = rand64();
         end
         1: begin
            idx = 64'($urandom_range(20));
            off = 64'($urandom_range(20));
         end
         default: begin
            idx = '1 - 64'($urandom_range(3000));
            off = '1 - 64'($urandom_range(3000));
         end
      endcase
      for (i = 0; i < n; i++) begin
         if (i > 0) begin
            if (i == bad_at) begin
               case ($urandom_range(3))
                  0: off = off + 64'($urandom_range(stride, 1));
                  1: idx = idx + 64'($urandom_range(stride, 1));
                  2: off = off - 64'($urandom_range(stride));
                  default: idx = rand64();
               endcase
            end else begin
               idx = idx + 64'($urandom_range(stride, 1));
               off = off + 64'($urandom_range(stride, 1));
            end
         end
         if ($urandom_range(19) == 0) send_item(REQ_UNUSED, rand64(), rand64());
         send_item(safl_pkg::REQ_APPEND, idx, off);
         keys.push_back(idx);
      end
      m = $urandom_range(6, 1);
      for (i = 0; i < m; i++) begin
         case ($urandom_range(5))
            0: key = '0;
            1: key = '1;
            2: key = rand64();
            default: begin
               if (keys.size() > 0) begin
                  key = keys[$urandom_range(keys.size() - 1)];
                  case ($urandom_range(2))
                     0: key = key - 64'd1;
                     1: key = key + 64'd1;
                     default: ;
                  endcase
               end else begin
                  key = rand64();
               end
            end
         endcase
         if ($urandom_range(19) == 0) send_item(REQ_UNUSED, rand64(), rand64());
         send_item(safl_pkg::REQ_LOOKUP, key, rand64());
      end
   endtask

   task automatic pressure_burst();
      int k;
      rsp_hold_left = 400;
      for (k = 0; k < 12; k++) begin
         send_item((k % 3 == 2) ? safl_pkg::REQ_APPEND : safl_pkg::REQ_LOOKUP,
                   rand64(), rand64());
      end
      drain_results();
   endtask

   initial begin
      int seq_no;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idle_mode(3);
      run_directed();
      set_idle_mode(0);
      fill_table();
      seq_no = 0;
      while (counted_transfers < TOTAL_TRANSFERS) begin
         if (seq_no % 5 == 0) begin
            drain_results();
            set_idle_mode((seq_no / 5) % 4);
         end
         if (seq_no % 20 == 3) pressure_burst();
         run_sequence();
         seq_no++;
      end
      drain_results();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tuser, rsp_tdata[63:0], rsp_tdata[127:64]);
         end
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      #15_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/safl_pkg.sv
rtl/core/safl_anchor_ram.sv
rtl/core/sorted_anchor_floor_lookup.sv
test/sorted_anchor_floor_lookup_test.sv
